// ===== hw/rtl/usb_control_request_engine_core_defines.svh =====
// assertion macros for the control request engine
`ifndef USB_CONTROL_REQUEST_ENGINE_CORE_DEFINES_SVH
`define USB_CONTROL_REQUEST_ENGINE_CORE_DEFINES_SVH
// property that must hold whenever reset is released
`define UCRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked in the following cycle
`define UCRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/ucre_pkg.sv =====
// ----------------------------------------------------------------------------
// ucre_pkg
// types and constants shared by the control request engine
// ----------------------------------------------------------------------------
package ucre_pkg;
  localparam int unsigned MaxPacket    = 64;
  localparam int unsigned NumConfigs   = 1;
  localparam int unsigned NumIfaces    = 2;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned AddrW        = 5;

  typedef enum logic [2:0] {
    KindSetup = 3'd0, KindInDone = 3'd1, KindOutDone = 3'd2, KindRxStart = 3'd3,
    KindReset = 3'd4, KindSuspend = 3'd5, KindResume = 3'd6, KindDisconnect = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    ActNone = 4'd0, ActStallEp0 = 4'd1, ActStallEp = 4'd2, ActSendZlp = 4'd3,
    ActExpectZlp = 4'd4, ActTransmit = 4'd5, ActReceive = 4'd6, ActSetAddr = 4'd7,
    ActClassFwd = 4'd8, ActClassInit = 4'd9, ActClassDeinit = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    StDefault = 2'd0, StAddressed = 2'd1, StConfigured = 2'd2, StSuspended = 2'd3
  } dev_state_e;

  typedef enum logic [2:0] {
    PhIdle = 3'd0, PhSetup = 3'd1, PhDataIn = 3'd2, PhDataOut = 3'd3,
    PhStatusIn = 3'd4, PhStatusOut = 3'd5
  } phase_e;

  // standard request numbers
  localparam logic [7:0] CodeGetStatus    = 8'd0;
  localparam logic [7:0] CodeClearFeature = 8'd1;
  localparam logic [7:0] CodeSetFeature   = 8'd3;
  localparam logic [7:0] CodeSetAddress   = 8'd5;
  localparam logic [7:0] CodeGetDesc      = 8'd6;
  localparam logic [7:0] CodeGetConfig    = 8'd8;
  localparam logic [7:0] CodeSetConfig    = 8'd9;

  // recipients and request type in bmRequestType
  localparam logic [4:0] RecipDevice    = 5'd0;
  localparam logic [4:0] RecipInterface = 5'd1;
  localparam logic [4:0] RecipEndpoint  = 5'd2;
  localparam logic [1:0] ReqTypeClass   = 2'd1;

  // descriptor types, feature selectors and data sources
  localparam logic [7:0]  DescTypeDevice = 8'd1;
  localparam logic [7:0]  DescTypeConfig = 8'd2;
  localparam logic [7:0]  DescTypeString = 8'd3;
  localparam logic [15:0] FeatureSelHalt   = 16'd0;
  localparam logic [15:0] FeatureSelWakeup = 16'd1;
  localparam logic [3:0]  DataSrcDevice = 4'd1;
  localparam logic [3:0]  DataSrcConfig = 4'd2;
  localparam logic [3:0]  DataSrcString = 4'd3;

  localparam logic [AddrW-1:0] RegDevDesc = 5'd0;
  localparam logic [AddrW-1:0] RegCfgDesc = 5'd4;
  localparam logic [AddrW-1:0] RegLangid  = 5'd8;
  localparam logic [AddrW-1:0] RegMaker   = 5'd12;
  localparam logic [AddrW-1:0] RegProduct = 5'd16;
  localparam logic [AddrW-1:0] RegSerial  = 5'd20;
  localparam logic [AddrW-1:0] RegCfgName = 5'd24;
  localparam logic [AddrW-1:0] RegIfName  = 5'd28;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic [3:0]  endpoint_number;
    logic        endpoint_halted;
    logic        class_ok;
    logic [15:0] receive_length;
  } req_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  endpoint_addr;
    logic [3:0]  data_source;
    logic [15:0] xfer_length;
    logic [15:0] immediate_value;
    logic [6:0]  device_address;
    logic [3:0]  config_number;
    logic        last;
  } act_t;

  // a classified item: up to three actions and how many of them are used
  typedef struct packed {
    act_t [2:0]  acts;
    logic [1:0]  count;
  } batch_t;

  typedef struct packed {
    logic [7:0]  dev_len;
    logic [15:0] cfg_len;
    logic [7:0]  langid_len;
    logic [7:0]  maker_len;
    logic [7:0]  product_len;
    logic [7:0]  serial_len;
    logic [7:0]  cfgname_len;
    logic [7:0]  ifname_len;
  } regs_t;

  function automatic act_t mk(action_e a, logic [7:0] ep, logic [3:0] src,
                              logic [15:0] len, logic [15:0] imm,
                              logic [6:0] adr, logic [3:0] cfg);
    act_t r;
    r.action = a; r.endpoint_addr = ep; r.data_source = src; r.xfer_length = len;
    r.immediate_value = imm; r.device_address = adr; r.config_number = cfg;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] min16(logic [15:0] a, logic [15:0] b);
    return (a < b) ? a : b;
  endfunction
endpackage

// ===== hw/rtl/ucre_regs.sv =====
// ----------------------------------------------------------------------------
// ucre_regs
// apb register file holding the descriptor lengths
// ----------------------------------------------------------------------------
module ucre_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ucre_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output ucre_pkg::regs_t          regs_o
);
  import ucre_pkg::*;
  regs_t regs_q, regs_d;
  logic  wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign regs_o = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (wr) begin
      case (paddr)
        RegDevDesc: regs_d.dev_len     = pwdata[7:0];
        RegCfgDesc: regs_d.cfg_len     = pwdata[15:0];
        RegLangid:  regs_d.langid_len  = pwdata[7:0];
        RegMaker:   regs_d.maker_len   = pwdata[7:0];
        RegProduct: regs_d.product_len = pwdata[7:0];
        RegSerial:  regs_d.serial_len  = pwdata[7:0];
        RegCfgName: regs_d.cfgname_len = pwdata[7:0];
        RegIfName:  regs_d.ifname_len  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegDevDesc: prdata = {24'd0, regs_q.dev_len};
      RegCfgDesc: prdata = {16'd0, regs_q.cfg_len};
      RegLangid:  prdata = {24'd0, regs_q.langid_len};
      RegMaker:   prdata = {24'd0, regs_q.maker_len};
      RegProduct: prdata = {24'd0, regs_q.product_len};
      RegSerial:  prdata = {24'd0, regs_q.serial_len};
      RegCfgName: prdata = {24'd0, regs_q.cfgname_len};
      RegIfName:  prdata = {24'd0, regs_q.ifname_len};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{dev_len: 8'd18, default: '0};
    end else begin
      regs_q <= regs_d;
    end
  end
endmodule

// ===== hw/rtl/ucre_front.sv =====
// ----------------------------------------------------------------------------
// ucre_front
// accepts items, updates the device state and classifies them into actions
// ----------------------------------------------------------------------------
module ucre_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ucre_pkg::req_t   req_i,
  input  ucre_pkg::regs_t  regs_i,
  input  logic             full_i,
  output logic             accept_o,
  output logic             push_o,
  output ucre_pkg::batch_t batch_o
);
  import ucre_pkg::*;

  logic [1:0]  dev_q, dev_d, sav_q, sav_d;
  logic [6:0]  adr_q, adr_d;
  logic [3:0]  cfg_q, cfg_d;
  logic        wake_q, wake_d;
  logic [2:0]  ph_q, ph_d;
  logic [15:0] tx_q, tx_d, rx_q, rx_d;
  batch_t      b;

  assign accept_o = valid_i & ~full_i;

  always_comb begin
    logic [7:0]  rtype, code, ep, type_b, idx_b, cfgv;
    logic [15:0] val, idx, wlen, dlen, rest;
    logic [3:0]  src;
    logic        ok, live, known;
    rtype = req_i.request_type; code = req_i.request_code;
    val = req_i.value_word; idx = req_i.index_word; wlen = req_i.length_word;
    ok = req_i.class_ok; ep = idx[7:0];
    type_b = val[15:8]; idx_b = val[7:0]; cfgv = val[7:0];
    live = (dev_q == StAddressed) || (dev_q == StConfigured);
    dev_d = dev_q; sav_d = sav_q; adr_d = adr_q; cfg_d = cfg_q; wake_d = wake_q;
    ph_d = ph_q; tx_d = tx_q; rx_d = rx_q;
    b = '0; src = '0; known = 1'b0; dlen = '0; rest = '0;
    case (kind_e'(req_i.kind))
      KindSetup: begin
        ph_d = PhSetup;
        if (rtype[4:0] == RecipDevice) begin
          case (code)
            CodeGetDesc: begin
              if (type_b == DescTypeDevice) begin
                src = DataSrcDevice; known = 1'b1; dlen = {8'd0, regs_i.dev_len};
              end else if (type_b == DescTypeConfig) begin
                src = DataSrcConfig; known = 1'b1; dlen = regs_i.cfg_len;
              end else if (type_b == DescTypeString && idx_b <= 8'd5) begin
                src = DataSrcString + idx_b[3:0]; known = 1'b1;
                case (idx_b[2:0])
                  3'd0: dlen = {8'd0, regs_i.langid_len};
                  3'd1: dlen = {8'd0, regs_i.maker_len};
                  3'd2: dlen = {8'd0, regs_i.product_len};
                  3'd3: dlen = {8'd0, regs_i.serial_len};
                  3'd4: dlen = {8'd0, regs_i.cfgname_len};
                  default: dlen = {8'd0, regs_i.ifname_len};
                endcase
              end
              if (!known) begin
                b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
              end else if (wlen == 16'd0) begin
                ph_d = PhStatusIn;
                b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd1;
              end else if (dlen == 16'd0) begin
                b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
              end else begin
                tx_d = min16(dlen, wlen); ph_d = PhDataIn;
                b.acts[0] = mk(ActTransmit, 8'h80, src, tx_d, '0, '0, '0); b.count = 2'd1;
              end
            end
            CodeSetAddress: begin
              if (idx != 16'd0 || wlen != 16'd0 || dev_q == StConfigured) begin
                b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
              end else begin
                adr_d = val[6:0]; ph_d = PhStatusIn;
                b.acts[0] = mk(ActSetAddr, 8'h00, '0, '0, '0, val[6:0], '0);
                b.acts[1] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd2;
                dev_d = (val[6:0] != 7'd0) ? StAddressed : StDefault;
              end
            end
            CodeSetConfig: begin
              if (cfgv > 8'(NumConfigs)) begin
                b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
              end else if (dev_q == StAddressed) begin
                if (cfgv != 8'd0) begin
                  cfg_d = cfgv[3:0]; dev_d = StConfigured; sav_d = StConfigured;
                  b.acts[0] = mk(ActClassInit, 8'h00, '0, '0, '0, '0, cfgv[3:0]);
                  if (!ok) b.acts[1] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
                  else begin
                    ph_d = PhStatusIn; b.acts[1] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
                  end
                  b.count = 2'd2;
                end else begin
                  ph_d = PhStatusIn;
                  b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd1;
                end
              end else if (dev_q == StConfigured) begin
                if (cfgv == 8'd0) begin
                  dev_d = StAddressed; sav_d = StAddressed; cfg_d = '0;
                  b.acts[0] = mk(ActClassDeinit, 8'h00, '0, '0, '0, '0, cfg_q);
                  if (!ok) b.acts[1] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
                  else begin
                    ph_d = PhStatusIn; b.acts[1] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
                  end
                  b.count = 2'd2;
                end else if (cfgv[3:0] != cfg_q) begin
                  cfg_d = cfgv[3:0];
                  b.acts[0] = mk(ActClassDeinit, 8'h00, '0, '0, '0, '0, cfg_q);
                  b.acts[1] = mk(ActClassInit, 8'h00, '0, '0, '0, '0, cfgv[3:0]);
                  if (!ok) b.acts[2] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
                  else begin
                    ph_d = PhStatusIn; b.acts[2] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
                  end
                  b.count = 2'd3;
                end else begin
                  ph_d = PhStatusIn;
                  b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd1;
                end
              end else begin
                b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
              end
            end
            CodeGetConfig: begin
              if (wlen == 16'd1 && (dev_q == StAddressed || dev_q == StConfigured)) begin
                tx_d = 16'd1; ph_d = PhDataIn;
                b.acts[0] = mk(ActTransmit, 8'h80, '0, 16'd1,
                               (dev_q == StConfigured) ? {12'd0, cfg_q} : 16'd0, '0, '0);
              end else b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
              b.count = 2'd1;
            end
            CodeGetStatus: begin
              if (live) begin
                tx_d = min16(16'd2, wlen); ph_d = PhDataIn;
                b.acts[0] = mk(ActTransmit, 8'h80, '0, tx_d, {14'd0, wake_q, 1'b1}, '0, '0);
              end else b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
              b.count = 2'd1;
            end
            CodeSetFeature: begin
              if (val == FeatureSelWakeup) begin
                wake_d = 1'b1; ph_d = PhStatusIn;
                b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
              end else b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
              b.count = 2'd1;
            end
            CodeClearFeature: begin
              if (live && val == FeatureSelWakeup) begin
                wake_d = 1'b0; ph_d = PhStatusIn;
                b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
              end else b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
              b.count = 2'd1;
            end
            default: begin
              b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
            end
          endcase
        end else if (rtype[4:0] == RecipInterface) begin
          if (dev_q == StConfigured && ep <= 8'(NumIfaces)) begin
            b.acts[0] = mk(ActClassFwd, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
            if (wlen == 16'd0) begin
              ph_d = PhStatusIn;
              b.acts[1] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd2;
            end
          end else begin
            b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
          end
        end else if (rtype[4:0] == RecipEndpoint) begin
          if (rtype[6:5] == ReqTypeClass) begin
            b.acts[0] = mk(ActClassFwd, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
          end else if (dev_q == StAddressed) begin
            b.acts[0] = (ep[6:0] != 7'd0) ? mk(ActStallEp, ep, '0, '0, '0, '0, '0)
                                         : mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0);
            b.count = 2'd1;
          end else if (dev_q != StConfigured) begin
            b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
          end else begin
            case (code)
              CodeSetFeature: begin
                ph_d = PhStatusIn;
                if (ep[6:0] != 7'd0 && val == FeatureSelHalt) begin
                  b.acts[0] = mk(ActStallEp, ep, '0, '0, '0, '0, '0);
                  b.acts[1] = mk(ActClassFwd, 8'h00, '0, '0, '0, '0, '0);
                  b.acts[2] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd3;
                end else begin
                  b.acts[0] = mk(ActClassFwd, 8'h00, '0, '0, '0, '0, '0);
                  b.acts[1] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd2;
                end
              end
              CodeClearFeature: begin
                if (val == FeatureSelHalt) begin
                  ph_d = PhStatusIn;
                  if (ep[6:0] != 7'd0) begin
                    b.acts[0] = mk(ActStallEp, ep, '0, '0, '0, '0, '0);
                    b.acts[1] = mk(ActClassFwd, 8'h00, '0, '0, '0, '0, '0);
                    b.acts[2] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd3;
                  end else begin
                    b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0); b.count = 2'd1;
                  end
                end
              end
              CodeGetStatus: begin
                tx_d = min16(16'd2, wlen); ph_d = PhDataIn;
                b.acts[0] = mk(ActTransmit, 8'h80, '0, tx_d,
                               {15'd0, req_i.endpoint_halted}, '0, '0);
                b.count = 2'd1;
              end
              default: begin
                b.acts[0] = mk(ActStallEp0, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
              end
            endcase
          end
        end else begin
          b.acts[0] = mk(ActStallEp, rtype[7] ? 8'h80 : 8'h00, '0, '0, '0, '0, '0);
          b.count = 2'd1;
        end
      end
      KindInDone: begin
        if (req_i.endpoint_number == 4'd0 && ph_q == PhDataIn) begin
          if (tx_q > 16'(MaxPacket)) begin
            rest = tx_q - 16'(MaxPacket); tx_d = rest;
            b.acts[0] = mk(ActTransmit, 8'h80, '0, min16(rest, 16'(MaxPacket)), '0, '0, '0);
            b.acts[1] = mk(ActExpectZlp, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd2;
          end else if (tx_q == 16'(MaxPacket)) begin
            tx_d = '0; ph_d = PhStatusOut;
            b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
            b.acts[1] = mk(ActExpectZlp, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd2;
          end else begin
            ph_d = PhStatusOut;
            b.acts[0] = mk(ActExpectZlp, 8'h00, '0, '0, '0, '0, '0); b.count = 2'd1;
          end
        end
      end
      KindOutDone: begin
        if (req_i.endpoint_number == 4'd0 && ph_q == PhDataOut) begin
          if (rx_q > 16'(MaxPacket)) begin
            rest = rx_q - 16'(MaxPacket); rx_d = rest;
            b.acts[0] = mk(ActReceive, 8'h00, '0, min16(rest, 16'(MaxPacket)), '0, '0, '0);
          end else begin
            ph_d = PhStatusIn;
            b.acts[0] = mk(ActSendZlp, 8'h80, '0, '0, '0, '0, '0);
          end
          b.count = 2'd1;
        end
      end
      KindRxStart: begin
        rx_d = req_i.receive_length; ph_d = PhDataOut;
        b.acts[0] = mk(ActReceive, 8'h00, '0, req_i.receive_length, '0, '0, '0);
        b.count = 2'd1;
      end
      KindReset: begin
        dev_d = StDefault; sav_d = StDefault; wake_d = 1'b0; adr_d = '0; cfg_d = '0;
        ph_d = PhIdle;
      end
      KindSuspend: begin
        sav_d = dev_q; dev_d = StSuspended;
      end
      KindResume: begin
        if (dev_q == StSuspended) dev_d = sav_q;
      end
      default: begin
        dev_d = StDefault; sav_d = StDefault; wake_d = 1'b0; adr_d = '0; cfg_d = '0;
      end
    endcase
    case (b.count)
      2'd1: b.acts[0].last = 1'b1;
      2'd2: b.acts[1].last = 1'b1;
      2'd3: b.acts[2].last = 1'b1;
      default: ;
    endcase
  end

  assign batch_o = b;
  assign push_o  = accept_o & (b.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= StDefault; sav_q <= StDefault; adr_q <= '0; cfg_q <= '0;
      wake_q <= 1'b0; ph_q <= PhIdle; tx_q <= '0; rx_q <= '0;
    end else if (accept_o) begin
      dev_q <= dev_d; sav_q <= sav_d; adr_q <= adr_d; cfg_q <= cfg_d;
      wake_q <= wake_d; ph_q <= ph_d; tx_q <= tx_d; rx_q <= rx_d;
    end
  end
endmodule

// ===== hw/rtl/ucre_queue.sv =====
// ----------------------------------------------------------------------------
// ucre_queue
// short fifo of classified batches between front and back
// ----------------------------------------------------------------------------
module ucre_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ucre_pkg::batch_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output ucre_pkg::batch_t data_o
);
  import ucre_pkg::*;
  batch_t      mem_q [QueueDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'(QueueDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ===== hw/rtl/ucre_back.sv =====
// ----------------------------------------------------------------------------
// ucre_back
// plays the actions of each batch out one per cycle, unless stalled, into an output register
// ----------------------------------------------------------------------------
module ucre_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  ucre_pkg::batch_t batch_i,
  output logic             pop_o,
  output logic             valid_o,
  output ucre_pkg::act_t   act_o,
  input  logic             stall_i
);
  import ucre_pkg::*;
  logic [1:0] sel_q;
  logic       vld_q;
  act_t       out_q;
  logic       load;

  assign load  = ~empty_i & (~vld_q | ~stall_i);
  assign pop_o = load & (sel_q == batch_i.count - 2'd1);
  assign valid_o = vld_q;
  assign act_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (load) out_q <= batch_i.acts[sel_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0; vld_q <= 1'b0;
    end else begin
      if (load) vld_q <= 1'b1;
      else if (~stall_i) vld_q <= 1'b0;
      if (pop_o) sel_q <= '0;
      else if (load) sel_q <= sel_q + 2'd1;
    end
  end
endmodule

// ===== hw/rtl/usb_control_request_engine_core.sv =====
// ----------------------------------------------------------------------------
// usb_control_request_engine_core
// usb ep0 control request engine: device state, request decode, action stream
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// req     | in        | req_valid_i/stall | req_i (ucre_pkg::req_t)
// act     | out       | act_valid_o/stall | act_o (ucre_pkg::act_t)
// apb     | in        | psel/penable      | descriptor length registers
//
// each transaction is classified in the cycle it is accepted; its up to three
// actions leave one per cycle, while act_stall_i is low, from a registered output,
// so the rate is set by the action count at the back end
// a two-entry queue between front and back lets inputs be taken while actions wait
// reset clears device state, queue and output valid; descriptor lengths reset
// to 18 for the device descriptor and 0 elsewhere
module usb_control_request_engine_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  ucre_pkg::req_t             req_i,
  output logic                       act_valid_o,
  input  logic                       act_stall_i,
  output ucre_pkg::act_t             act_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ucre_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ucre_pkg::*;
  regs_t  regs;
  batch_t batch_w, batch_r;
  logic   full, empty, push, pop, accept;

  ucre_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .regs_o(regs)
  );

  // front end: state update and classification
  ucre_front u_front (
    .clk_i, .rst_ni, .valid_i(req_valid_i), .req_i, .regs_i(regs), .full_i(full),
    .accept_o(accept), .push_o(push), .batch_o(batch_w)
  );

  // stall only while the queue is full
  assign req_stall_o = full;

  ucre_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(batch_w), .pop_i(pop),
    .full_o(full), .empty_o(empty), .data_o(batch_r)
  );

  ucre_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .batch_i(batch_r), .pop_o(pop),
    .valid_o(act_valid_o), .act_o, .stall_i(act_stall_i)
  );
endmodule

// ===== hw/rtl/ucre_checker.sv =====
// ----------------------------------------------------------------------------
// ucre_checker
// port level checks for the control request engine
// ----------------------------------------------------------------------------
`include "usb_control_request_engine_core_defines.svh"
module ucre_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_stall_o,
  input logic           act_valid_o,
  input logic           act_stall_i,
  input ucre_pkg::act_t act_o,
  input logic           pready
);
  import ucre_pkg::*;
  `UCRE_ASSERT(a_pready, pready, "pready low")
  `UCRE_ASSERT(a_no_none, !act_valid_o || act_o.action != ActNone, "empty action shown")
  `UCRE_ASSERT(a_range, !act_valid_o || act_o.action <= ActClassDeinit, "action code out of range")
  `UCRE_ASSERT_NEXT(a_hold, act_valid_o && act_stall_i, act_valid_o && $stable(act_o),
                    "stalled action changed")
  `UCRE_ASSERT_NEXT(a_req_hold, req_valid_i && req_stall_o, req_valid_i,
                    "stalled request withdrawn")
endmodule

bind usb_control_request_engine_core ucre_checker u_ucre_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .act_valid_o, .act_stall_i, .act_o,
  .pready
);

// ===== bench/ucre_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucre_tb_pkg
// request codes and field codes shared by the bench and the scoreboard
// ----------------------------------------------------------------------------
package ucre_tb_pkg;
  // standard request numbers
  localparam logic [7:0] ReqGetStatus    = 8'd0;
  localparam logic [7:0] ReqClearFeature = 8'd1;
  localparam logic [7:0] ReqSetFeature   = 8'd3;
  localparam logic [7:0] ReqSetAddress   = 8'd5;
  localparam logic [7:0] ReqGetDesc      = 8'd6;
  localparam logic [7:0] ReqGetConfig    = 8'd8;
  localparam logic [7:0] ReqSetConfig    = 8'd9;

  // recipients and request types in bmRequestType
  localparam logic [4:0] RcpDevice    = 5'd0;
  localparam logic [4:0] RcpInterface = 5'd1;
  localparam logic [4:0] RcpEndpoint  = 5'd2;
  localparam logic [1:0] TypeStandard = 2'd0;
  localparam logic [1:0] TypeClass    = 2'd1;

  // descriptor types and feature selectors
  localparam logic [7:0]  DescDevice   = 8'd1;
  localparam logic [7:0]  DescConfig   = 8'd2;
  localparam logic [7:0]  DescString   = 8'd3;
  localparam logic [15:0] FeatEpHalt   = 16'd0;
  localparam logic [15:0] FeatWakeup   = 16'd1;

  // data sources of a transmit
  localparam logic [3:0] SrcImmediate = 4'd0;
  localparam logic [3:0] SrcDevDesc   = 4'd1;
  localparam logic [3:0] SrcCfgDesc   = 4'd2;
  localparam logic [3:0] SrcLangid    = 4'd3;

  localparam logic [7:0] EpIn0  = 8'h80;
  localparam logic [7:0] EpOut0 = 8'h00;
endpackage

// ===== bench/ucre_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucre_scoreboard
// watches request, action and register traffic, predicts the action stream
// ----------------------------------------------------------------------------
module ucre_scoreboard
  import ucre_pkg::*;
  import ucre_tb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_stall_i,
  input  req_t             req_i,
  input  logic             act_valid_i,
  input  logic             act_stall_i,
  input  act_t             act_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  logic [15:0] desc_len[8];
  dev_state_e  dev_state, resume_state;
  logic [6:0]  bus_addr;
  logic [3:0]  cur_config;
  logic        wakeup;
  phase_e      ep0_phase;
  logic [15:0] tx_left, rx_left;

  act_t        batch[3];
  int          batch_n;
  act_t        action_q[$];

  task automatic put(action_e a, logic [7:0] ep, logic [3:0] src, logic [15:0] len,
                     logic [15:0] imm, logic [6:0] adr, logic [3:0] cfg);
    act_t r;
    if (batch_n < 3) begin
      r.action = a; r.endpoint_addr = ep; r.data_source = src; r.xfer_length = len;
      r.immediate_value = imm; r.device_address = adr; r.config_number = cfg;
      r.last = 1'b0;
      batch[batch_n] = r;
      batch_n++;
    end
  endtask

  task automatic stall_ep0();
    put(ActStallEp0, EpOut0, 0, 0, 0, 0, 0);
  endtask

  task automatic status_in();
    ep0_phase = PhStatusIn;
    put(ActSendZlp, EpIn0, 0, 0, 0, 0, 0);
  endtask

  task automatic status_out();
    ep0_phase = PhStatusOut;
    put(ActExpectZlp, EpOut0, 0, 0, 0, 0, 0);
  endtask

  task automatic send_data(logic [3:0] src, logic [15:0] len, logic [15:0] imm);
    tx_left = len;
    ep0_phase = PhDataIn;
    put(ActTransmit, EpIn0, src, len, imm, 0, 0);
  endtask

  task automatic descriptor(logic [15:0] value, logic [15:0] wlen);
    logic [3:0]  src;
    logic [15:0] have;
    if (value[15:8] == DescDevice) src = SrcDevDesc;
    else if (value[15:8] == DescConfig) src = SrcCfgDesc;
    else if (value[15:8] == DescString && value[7:0] <= 8'd5) src = SrcLangid + value[3:0];
    else begin
      stall_ep0();
      return;
    end
    have = desc_len[src - 1];
    if (wlen == 0) status_in();
    else if (have == 0) stall_ep0();
    else send_data(src, (have < wlen) ? have : wlen, 0);
  endtask

  task automatic set_config(logic [15:0] value, logic ok);
    logic [7:0] cfg;
    logic [3:0] old;
    cfg = value[7:0];
    old = cur_config;
    if (cfg > NumConfigs) begin
      stall_ep0();
    end else if (dev_state == StAddressed) begin
      if (cfg != 0) begin
        cur_config = cfg[3:0];
        dev_state = StConfigured;
        resume_state = StConfigured;
        put(ActClassInit, 0, 0, 0, 0, 0, cfg[3:0]);
        if (!ok) begin
          stall_ep0();
          return;
        end
      end
      status_in();
    end else if (dev_state == StConfigured) begin
      if (cfg == 0) begin
        dev_state = StAddressed;
        resume_state = StAddressed;
        cur_config = 0;
        put(ActClassDeinit, 0, 0, 0, 0, 0, old);
        if (!ok) begin
          stall_ep0();
          return;
        end
      end else if (cfg[3:0] != old) begin
        cur_config = cfg[3:0];
        put(ActClassDeinit, 0, 0, 0, 0, 0, old);
        put(ActClassInit, 0, 0, 0, 0, 0, cfg[3:0]);
        if (!ok) begin
          stall_ep0();
          return;
        end
      end
      status_in();
    end else begin
      stall_ep0();
    end
  endtask

  task automatic device_req(req_t r);
    logic live;
    live = (dev_state == StAddressed) || (dev_state == StConfigured);
    case (r.request_code)
      ReqGetDesc: descriptor(r.value_word, r.length_word);
      ReqSetAddress: begin
        if (r.index_word != 0 || r.length_word != 0 || dev_state == StConfigured) begin
          stall_ep0();
        end else begin
          bus_addr = r.value_word[6:0];
          put(ActSetAddr, 0, 0, 0, 0, bus_addr, 0);
          status_in();
          dev_state = (bus_addr != 0) ? StAddressed : StDefault;
        end
      end
      ReqSetConfig: set_config(r.value_word, r.class_ok);
      ReqGetConfig: begin
        if (r.length_word != 1) stall_ep0();
        else if (dev_state == StAddressed) send_data(SrcImmediate, 1, 0);
        else if (dev_state == StConfigured) send_data(SrcImmediate, 1, {12'd0, cur_config});
        else stall_ep0();
      end
      ReqGetStatus: begin
        if (live) send_data(SrcImmediate, (r.length_word < 2) ? r.length_word : 16'd2,
                            {14'd0, wakeup, 1'b1});
        else stall_ep0();
      end
      ReqSetFeature: begin
        if (r.value_word == FeatWakeup) begin
          wakeup = 1'b1;
          status_in();
        end else begin
          stall_ep0();
        end
      end
      ReqClearFeature: begin
        if (live && r.value_word == FeatWakeup) begin
          wakeup = 1'b0;
          status_in();
        end else begin
          stall_ep0();
        end
      end
      default: stall_ep0();
    endcase
  endtask

  task automatic endpoint_req(req_t r);
    logic [7:0] ep;
    ep = r.index_word[7:0];
    if (r.request_type[6:5] == TypeClass) begin
      put(ActClassFwd, 0, 0, 0, 0, 0, 0);
      return;
    end
    if (dev_state == StAddressed) begin
      if (ep[6:0] != 0) put(ActStallEp, ep, 0, 0, 0, 0, 0);
      else stall_ep0();
      return;
    end
    if (dev_state != StConfigured) begin
      stall_ep0();
      return;
    end
    case (r.request_code)
      ReqSetFeature: begin
        if (ep[6:0] != 0 && r.value_word == FeatEpHalt) put(ActStallEp, ep, 0, 0, 0, 0, 0);
        put(ActClassFwd, 0, 0, 0, 0, 0, 0);
        status_in();
      end
      ReqClearFeature: begin
        if (r.value_word == FeatEpHalt) begin
          if (ep[6:0] != 0) begin
            put(ActStallEp, ep, 0, 0, 0, 0, 0);
            put(ActClassFwd, 0, 0, 0, 0, 0, 0);
          end
          status_in();
        end
      end
      ReqGetStatus: send_data(SrcImmediate, (r.length_word < 2) ? r.length_word : 16'd2,
                              {15'd0, r.endpoint_halted});
      default: stall_ep0();
    endcase
  endtask

  task automatic forget_device();
    dev_state = StDefault;
    resume_state = StDefault;
    wakeup = 1'b0;
    bus_addr = 0;
    cur_config = 0;
  endtask

  task automatic predict_actions(req_t r);
    batch_n = 0;
    case (kind_e'(r.kind))
      KindSetup: begin
        ep0_phase = PhSetup;
        case (r.request_type[4:0])
          RcpDevice: device_req(r);
          RcpInterface: begin
            if (dev_state == StConfigured && r.index_word[7:0] <= NumIfaces) begin
              put(ActClassFwd, 0, 0, 0, 0, 0, 0);
              if (r.length_word == 0) status_in();
            end else begin
              stall_ep0();
            end
          end
          RcpEndpoint: endpoint_req(r);
          default: put(ActStallEp, r.request_type[7] ? EpIn0 : EpOut0, 0, 0, 0, 0, 0);
        endcase
      end
      KindInDone: begin
        if (r.endpoint_number == 0 && ep0_phase == PhDataIn) begin
          if (tx_left > MaxPacket) begin
            tx_left = tx_left - MaxPacket;
            put(ActTransmit, EpIn0, SrcImmediate,
                (tx_left < MaxPacket) ? tx_left : 16'(MaxPacket), 0, 0, 0);
            put(ActExpectZlp, EpOut0, 0, 0, 0, 0, 0);
          end else if (tx_left == MaxPacket) begin
            tx_left = 0;
            status_in();
            status_out();
          end else begin
            status_out();
          end
        end
      end
      KindOutDone: begin
        if (r.endpoint_number == 0 && ep0_phase == PhDataOut) begin
          if (rx_left > MaxPacket) begin
            rx_left = rx_left - MaxPacket;
            put(ActReceive, EpOut0, 0, (rx_left < MaxPacket) ? rx_left : 16'(MaxPacket),
                0, 0, 0);
          end else begin
            status_in();
          end
        end
      end
      KindRxStart: begin
        rx_left = r.receive_length;
        ep0_phase = PhDataOut;
        put(ActReceive, EpOut0, 0, rx_left, 0, 0, 0);
      end
      KindReset: begin
        forget_device();
        ep0_phase = PhIdle;
      end
      KindSuspend: begin
        resume_state = dev_state;
        dev_state = StSuspended;
      end
      KindResume: if (dev_state == StSuspended) dev_state = resume_state;
      default: forget_device();
    endcase
    if (batch_n > 0) batch[batch_n - 1].last = 1'b1;
    for (int i = 0; i < batch_n; i++) action_q.push_back(batch[i]);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: action %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    act_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) desc_len[i] = 0;
      desc_len[0] = 18;
      forget_device();
      ep0_phase = PhIdle;
      tx_left = 0;
      rx_left = 0;
      action_q.delete();
      fail_count_o = 0;
    end else begin
      // register write lands at the access phase
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[4:2] == 3'd1) desc_len[1] = pwdata_i[15:0];
        else desc_len[paddr_i[4:2]] = {8'd0, pwdata_i[7:0]};
      end
      if (act_valid_i && !act_stall_i) begin
        if (action_q.size() == 0) begin
          $display("%0t: unexpected action, expected none, got %p", $time, act_i);
          fail_count_o++;
        end else begin
          want = action_q.pop_front();
          check_field("action", want.action, act_i.action);
          check_field("endpoint_addr", want.endpoint_addr, act_i.endpoint_addr);
          check_field("data_source", want.data_source, act_i.data_source);
          check_field("xfer_length", want.xfer_length, act_i.xfer_length);
          check_field("immediate_value", want.immediate_value, act_i.immediate_value);
          check_field("device_address", want.device_address, act_i.device_address);
          check_field("config_number", want.config_number, act_i.config_number);
          check_field("last", want.last, act_i.last);
        end
      end
      if (req_valid_i && !req_stall_i) predict_actions(req_i);
    end
    pending_o = action_q.size();
  end

endmodule

// ===== bench/tb_usb_control_request_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_control_request_engine_core
// drives control transactions and register settings into the request engine;
// the scoreboard beside it predicts and checks every action
// ----------------------------------------------------------------------------
module tb_usb_control_request_engine_core;
  import ucre_pkg::*;
  import ucre_tb_pkg::*;

  localparam int CycleLimit = 250000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             req_valid_i = 1'b0;
  logic             req_stall_o;
  req_t             req_i = '0;
  logic             act_valid_o;
  logic             act_stall_i = 1'b0;
  act_t             act_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count, pending, cycles;
  // calm: no idling on either side; squeeze: receiver holds off for a long stretch
  logic calm = 1'b0;
  logic squeeze = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  usb_control_request_engine_core dut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .act_valid_o, .act_stall_i, .act_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ucre_scoreboard sb (
    .clk_i, .rst_ni,
    .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .act_valid_i(act_valid_o), .act_stall_i, .act_i(act_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("usb_control_request_engine_core test failed");
      $finish;
    end
  end

  // action receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze) begin
        act_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        act_stall_i <= 1'b0;
        squeeze = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        act_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        act_stall_i <= 1'b0;
      end
    end
  end

  // register write: setup phase, then access phase
  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_lengths(logic [7:0] dev, logic [15:0] cfg, logic [7:0] s0,
                             logic [7:0] s1, logic [7:0] s2, logic [7:0] s3,
                             logic [7:0] s4, logic [7:0] s5);
    reg_write(RegDevDesc, {24'd0, dev});
    reg_write(RegCfgDesc, {16'd0, cfg});
    reg_write(RegLangid, {24'd0, s0});
    reg_write(RegMaker, {24'd0, s1});
    reg_write(RegProduct, {24'd0, s2});
    reg_write(RegSerial, {24'd0, s3});
    reg_write(RegCfgName, {24'd0, s4});
    reg_write(RegIfName, {24'd0, s5});
    @(posedge clk_i);
  endtask

  // let every expected action drain, plus a margin for in-flight work
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // offer one transaction and hold it until it is taken
  task automatic send(req_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    forever begin
      @(negedge clk_i);
      if (!req_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  function automatic req_t setup(logic [7:0] rt, logic [7:0] code, logic [15:0] val,
                                 logic [15:0] idx, logic [15:0] len);
    req_t r;
    r = '0;
    r.kind = KindSetup;
    r.request_type = rt;
    r.request_code = code;
    r.value_word = val;
    r.index_word = idx;
    r.length_word = len;
    r.class_ok = 1'b1;
    return r;
  endfunction

  function automatic req_t bus_event(kind_e k, logic [3:0] ep, logic [15:0] rlen);
    req_t r;
    r = '0;
    r.kind = k;
    r.endpoint_number = ep;
    r.receive_length = rlen;
    return r;
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd64;
      4: return 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed traffic with random content, the rest noise
  task automatic random_item();
    req_t       r;
    logic [7:0] codes[7];
    int         sel;
    codes = '{ReqGetStatus, ReqClearFeature, ReqSetFeature, ReqSetAddress,
              ReqGetDesc, ReqGetConfig, ReqSetConfig};
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      // enumeration: address then configuration
      send(setup({1'b0, TypeStandard, RcpDevice}, ReqSetAddress,
                 16'($urandom_range(1, 127)), 0, 0));
      r = setup({1'b0, TypeStandard, RcpDevice}, ReqSetConfig,
                16'($urandom_range(0, 2)), 0, 0);
      r.class_ok = ($urandom_range(0, 7) != 0);
      send(r);
      return;
    end else if (sel < 35) begin
      r = setup({$urandom_range(0, 1) == 1, TypeStandard, RcpDevice},
                codes[$urandom_range(0, 6)], 0, 0, pick_len());
      case (r.request_code)
        ReqGetDesc: r.value_word = {8'($urandom_range(0, 4)), 8'($urandom_range(0, 7))};
        ReqSetAddress: begin
          r.value_word = 16'($urandom_range(0, 127));
          if ($urandom_range(0, 3) != 0) r.length_word = 0;
        end
        ReqSetConfig: r.value_word = 16'($urandom_range(0, 2));
        ReqGetConfig: if ($urandom_range(0, 2) != 0) r.length_word = 1;
        default: r.value_word = 16'($urandom_range(0, 2));
      endcase
      if ($urandom_range(0, 9) == 0) r.index_word = 16'($urandom);
      r.class_ok = ($urandom_range(0, 7) != 0);
    end else if (sel < 50) begin
      r = bus_event(KindInDone, ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd0, 0);
    end else if (sel < 57) begin
      r = bus_event(KindRxStart, 0, pick_len());
    end else if (sel < 67) begin
      r = bus_event(KindOutDone, ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd0, 0);
    end else if (sel < 80) begin
      r = setup({$urandom_range(0, 1) == 1, 2'($urandom_range(0, 1)),
                 5'($urandom_range(1, 2))},
                codes[$urandom_range(0, 2)], 16'($urandom_range(0, 1)),
                16'($urandom_range(0, 255)), pick_len());
      r.endpoint_halted = 1'($urandom);
    end else if (sel < 87) begin
      r = bus_event(kind_e'($urandom_range(4, 7)), 0, 0);
    end else begin
      r.kind = 3'($urandom);
      r.request_type = 8'($urandom);
      r.request_code = 8'($urandom);
      r.value_word = 16'($urandom);
      r.index_word = 16'($urandom);
      r.length_word = 16'($urandom);
      r.endpoint_number = 4'($urandom);
      r.endpoint_halted = 1'($urandom);
      r.class_ok = 1'($urandom);
      r.receive_length = 16'($urandom);
    end
    send(r);
  endtask

  initial begin
    req_t r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_lengths(8'd18, 16'd150, 8'd4, 8'd30, 8'd70, 8'd1, 8'd255, 8'd64);

    // directed: device still in default state
    send(setup(8'h80, ReqGetStatus, 0, 0, 2));               // not live, stall
    send(setup(8'h00, ReqSetAddress, 16'h7f, 0, 0));
    send(setup(8'h80, ReqGetDesc, {DescDevice, 8'd0}, 0, 16'hffff));
    send(bus_event(KindInDone, 0, 0));
    send(setup(8'h80, ReqGetDesc, {DescConfig, 8'd0}, 0, 0)); // zero wLength
    send(setup(8'h80, ReqGetDesc, {DescString, 8'd6}, 0, 64)); // unknown string
    send(setup(8'h80, ReqGetDesc, {DescConfig, 8'd0}, 0, 200));
    send(bus_event(KindInDone, 0, 0));                        // continuation
    send(bus_event(KindInDone, 0, 0));
    send(bus_event(KindInDone, 5, 0));                        // other endpoint
    send(setup(8'h02, ReqSetFeature, FeatEpHalt, 16'h81, 0)); // addressed, ep stall
    send(setup(8'h00, ReqSetConfig, 1, 0, 0));
    send(setup(8'h80, ReqGetConfig, 0, 0, 1));
    send(setup(8'h00, ReqSetConfig, 2, 0, 0));                // beyond configs
    send(setup(8'h00, ReqSetFeature, 16'd2, 0, 0));           // not wakeup
    send(setup(8'h00, ReqSetFeature, FeatWakeup, 0, 0));
    send(setup(8'h80, ReqGetStatus, 0, 0, 16'hffff));
    send(setup(8'h02, ReqSetFeature, FeatEpHalt, 16'h81, 0));
    send(setup(8'h02, ReqClearFeature, 16'd1, 16'h81, 0));    // not halt, silent
    r = setup(8'h82, ReqGetStatus, 0, 16'h02, 2);
    r.endpoint_halted = 1'b1;
    send(r);
    send(setup(8'h02, 8'hff, 0, 0, 0));                       // unknown ep request
    send(setup(8'h01, 8'h0a, 0, 16'd2, 0));                   // interface forward
    send(setup(8'h22, 8'h01, 0, 16'h01, 8));                  // class, endpoint
    send(setup(8'h9f, 8'h00, 0, 0, 0));                       // unknown recipient
    r = setup(8'h00, ReqSetConfig, 0, 0, 0);
    r.class_ok = 1'b0;
    send(r);
    send(bus_event(KindSuspend, 0, 0));
    send(bus_event(KindResume, 0, 0));
    send(bus_event(KindResume, 0, 0));
    send(bus_event(KindRxStart, 0, 16'd130));
    repeat (3) send(bus_event(KindOutDone, 0, 0));
    send(bus_event(KindReset, 0, 0));
    send(bus_event(KindDisconnect, 0, 0));
    req_valid_i <= 1'b0;
    drain();

    // random phases across register settings, extremes included
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_lengths(0, 0, 0, 0, 0, 0, 0, 0);
        1: set_lengths(8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        default: set_lengths(8'($urandom), 16'($urandom_range(0, 600)), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
      endcase
      // the receiver holds off while offers keep coming
      if (phase == 1) squeeze = 1'b1;
      if (phase == 3) calm = 1'b1;
      repeat (20) random_item();
      req_valid_i <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("usb_control_request_engine_core test passed");
    end else begin
      $display("usb_control_request_engine_core test failed");
    end
    $finish;
  end

endmodule
